@@ sv/bvp_pkg.sv @@
// Shared constants and types for the variable-width bit packer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package bvp_pkg;

   localparam int WORD_BITS         = 32;
   localparam int FIELD_BITS        = 64;
   localparam int DEFAULT_MAX_WORDS = 256;
   localparam int MAX_RESULTS       = 3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_LEN_ERR  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

   // One item's worth of results, handed from the append logic to the emitter
   typedef struct packed {
      logic [1:0]                   status;
      logic [1:0]                   count;
      logic [7:0]                   index;
      word_type [MAX_RESULTS-1:0]   words;
   } batch_type;

endpackage

@@ sv/bvp_req_if.sv @@
// Input channel of the bit packer: valid/ready handshake and field payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface bvp_req_if;
   logic        valid;
   logic        ready;
   logic        restart;
   logic [63:0] field_value;
   logic [6:0]  field_width;
   logic [3:0]  byte_count;

   modport source (output valid, restart, field_value, field_width, byte_count,
                   input ready);
   modport sink   (input valid, restart, field_value, field_width, byte_count,
                   output ready);
endinterface

@@ sv/bvp_rsp_if.sv @@
// Result channel of the bit packer: valid/ready handshake and word payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface bvp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  word_index;
   logic [31:0] word_value;
   logic        last;

   modport source (output valid, status, word_index, word_value, last,
                   input ready);
   modport sink   (input valid, status, word_index, word_value, last,
                   output ready);
endinterface

@@ sv/bvp_calc.sv @@
// Append logic: checks one field against the packer state, builds the
// words it touches and the next state. Depends on bvp_pkg.
`timescale 1ns / 1ps

module bvp_calc #(
   parameter int MAX_WORDS = bvp_pkg::DEFAULT_MAX_WORDS,
   localparam int POS_W    = $clog2(MAX_WORDS * 32 + 1)
) (
   input  logic [POS_W-1:0]   pos,
   input  bvp_pkg::word_type  partial,
   input  logic               restart,
   input  logic [63:0]        field_value,
   input  logic [6:0]         field_width,
   input  logic [3:0]         byte_count,
   output bvp_pkg::batch_type batch,
   output logic [POS_W-1:0]   next_pos,
   output bvp_pkg::word_type  next_partial
);
   import bvp_pkg::*;

   localparam int CAPACITY = MAX_WORDS * 32;

   logic [POS_W-1:0] pos_eff;
   logic [POS_W-1:0] first_word;
   word_type         part_eff;
   logic             len_err;
   logic             ovf_err;
   logic [POS_W:0]   pos_sum;
   logic [63:0]      masked;
   logic [95:0]      shifted;
   logic [4:0]       shift;
   logic [6:0]       span;
   logic [1:0]       count;
   word_type [MAX_RESULTS-1:0] words;
   word_type         last_word;

   always_comb begin
      // restart applies even when the item is then rejected
      pos_eff  = restart ? '0 : pos;
      part_eff = restart ? '0 : partial;

      len_err = (field_width == 7'd0) || (field_width > 7'(FIELD_BITS))
                || ({byte_count, 3'b000} < field_width);
      pos_sum = {1'b0, pos_eff} + (POS_W+1)'(field_width);
      ovf_err = pos_sum > (POS_W+1)'(CAPACITY);

      if (field_width >= 7'd64) begin
         masked = field_value;
      end else begin
         masked = field_value & ((64'd1 << field_width) - 64'd1);
      end

      shift   = pos_eff[4:0];
      shifted = {32'd0, masked} << shift;
      span    = {2'b00, shift} + field_width - 7'd1;
      count   = span[6:5] + 2'd1;

      words[0] = shifted[31:0] | part_eff;
      words[1] = shifted[63:32];
      words[2] = shifted[95:64];

      case (count)
         2'd2:    last_word = words[1];
         2'd3:    last_word = words[2];
         default: last_word = words[0];
      endcase

      first_word = pos_eff >> 5;

      if (len_err || ovf_err) begin
         batch.status = len_err ? STATUS_LEN_ERR : STATUS_OVERFLOW;
         batch.count  = 2'd1;
         batch.index  = 8'd0;
         batch.words  = '0;
         next_pos     = pos_eff;
         next_partial = part_eff;
      end else begin
         batch.status = STATUS_OK;
         batch.count  = count;
         batch.index  = 8'(first_word);
         batch.words  = words;
         next_pos     = pos_sum[POS_W-1:0];
         // a field that ends on a word boundary leaves nothing unfinished
         next_partial = (pos_sum[4:0] == 5'd0) ? '0 : last_word;
      end
   end

endmodule

@@ sv/bvp_emit.sv @@
// Result register: holds the words of one item and sends them one per
// transfer, in rising index order. Depends on bvp_pkg and bvp_rsp_if.
`timescale 1ns / 1ps

module bvp_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  bvp_pkg::batch_type batch,
   output logic               load_ready,
   bvp_rsp_if.source          rsp_chan
);
   import bvp_pkg::*;

   logic [1:0]                 count_ff, count_in;
   logic [1:0]                 status_ff, status_in;
   logic [7:0]                 index_ff, index_in;
   word_type [MAX_RESULTS-1:0] words_ff, words_in;
   logic                       transfer;

   assign transfer   = rsp_chan.valid && rsp_chan.ready;
   assign load_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_chan.ready);

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      index_in  = index_ff;
      words_in  = words_ff;
      if (load) begin
         count_in  = batch.count;
         status_in = batch.status;
         index_in  = batch.index;
         words_in  = batch.words;
      end else if (transfer) begin
         // advance to the next word of the item
         count_in = count_ff - 2'd1;
         index_in = index_ff + 8'd1;
         words_in = {word_type'(0), words_ff[MAX_RESULTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      status_ff <= status_in;
      index_ff  <= index_in;
      words_ff  <= words_in;
   end

   assign rsp_chan.valid      = count_ff != 2'd0;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.word_index = index_ff;
   assign rsp_chan.word_value = words_ff[0];
   assign rsp_chan.last       = count_ff == 2'd1;

endmodule

@@ sv/variable_width_bit_packer_core.sv @@
// An item's first result is valid once it moves from input register to result
// register. One item per cycle for single-word items while rsp_chan is ready;
// else the single result register holds an item until its 1 to 3 words are
// sent. Reset (synchronous): clears the bit position, the unfinished word and
// all valid flags; no clearing pass. Depends on bvp_pkg, bvp_calc, bvp_emit.
`timescale 1ns / 1ps

module variable_width_bit_packer_core #(
   parameter int MAX_WORDS = bvp_pkg::DEFAULT_MAX_WORDS
) (
   input  logic     clock,
   input  logic     reset,
   bvp_req_if.sink  req_chan,
   bvp_rsp_if.source rsp_chan
);
   import bvp_pkg::*;

   localparam int POS_W = $clog2(MAX_WORDS * 32 + 1);

   logic             in_valid_ff, in_valid_in;
   logic             restart_ff;
   logic [63:0]      value_ff;
   logic [6:0]       width_ff;
   logic [3:0]       bytes_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   word_type         partial_ff, partial_in;

   logic             req_transfer;
   logic             load;
   logic             load_ready;
   batch_type        batch;
   logic [POS_W-1:0] next_pos;
   word_type         next_partial;

   assign load           = in_valid_ff && load_ready;
   assign req_chan.ready = !in_valid_ff || load;
   assign req_transfer   = req_chan.valid && req_chan.ready;

   bvp_calc #(.MAX_WORDS(MAX_WORDS)) u_calc (
      .pos          (pos_ff),
      .partial      (partial_ff),
      .restart      (restart_ff),
      .field_value  (value_ff),
      .field_width  (width_ff),
      .byte_count   (bytes_ff),
      .batch        (batch),
      .next_pos     (next_pos),
      .next_partial (next_partial)
   );

   bvp_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .batch      (batch),
      .load_ready (load_ready),
      .rsp_chan   (rsp_chan)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_transfer) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
      // packer state moves on only when the item's results are taken over
      pos_in     = load ? next_pos : pos_ff;
      partial_in = load ? next_partial : partial_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         partial_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff      <= pos_in;
         partial_ff  <= partial_in;
      end
   end

   // hold the input register until the item is loaded
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         restart_ff <= req_chan.restart;
         value_ff   <= req_chan.field_value;
         width_ff   <= req_chan.field_width;
         bytes_ff   <= req_chan.byte_count;
      end
   end

endmodule
